// File: hdl/rmpi_pkg.sv
package rmpi_pkg;

  localparam int unsigned ID_W           = 5;
  localparam int unsigned PRIO_W         = 8;
  localparam int unsigned WAIT_SLOTS_DEF = 16;
  localparam int unsigned MAX_NEST_DEF   = 255;
  localparam int unsigned CMD_QDEPTH     = 2;

  typedef enum logic [3:0] {
    ST_ACQUIRED  = 4'd0,
    ST_NESTED    = 4'd1,
    ST_BLOCKED   = 4'd2,
    ST_QFULL     = 4'd3,
    ST_DFULL     = 4'd4,
    ST_UNNEST    = 4'd5,
    ST_FREED     = 4'd6,
    ST_HANDOVER  = 4'd7,
    ST_NOTHOLDER = 4'd8
  } status_e;

  typedef enum logic {
    CMD_LOCK   = 1'b0,
    CMD_UNLOCK = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_COMPACT
  } back_state_e;

  typedef struct packed {
    logic              opcode;
    logic [ID_W-1:0]   requester_id;
    logic [PRIO_W-1:0] requester_priority;
    logic [PRIO_W-1:0] base_priority;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic              wake_valid;
    logic [ID_W-1:0]   wake_thread;
    logic              boost_valid;
    logic [ID_W-1:0]   boost_thread;
    logic [PRIO_W-1:0] boost_priority;
    logic              restore_valid;
  } res_t;

  typedef struct packed {
    cmd_e              kind;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic              restore;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]   thread;
    logic [PRIO_W-1:0] level;
  } entry_t;

endpackage

// File: hdl/rmpi_ram.sv
module rmpi_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/rmpi_front.sv
module rmpi_front
  import rmpi_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic cmd_valid_o,
  output cmd_t cmd_o,
  input  logic cmd_pop_i
);

  localparam int unsigned PW = (CMD_QDEPTH > 1) ? $clog2(CMD_QDEPTH) : 1;
  localparam int unsigned NW = $clog2(CMD_QDEPTH + 1);

  cmd_t          slot_q [CMD_QDEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [NW-1:0] fill_q, fill_d;
  logic          push;
  logic          pop;
  cmd_t          cmd_new;

  assign busy = (fill_q == NW'(CMD_QDEPTH));
  assign push = start && !busy;
  assign pop  = cmd_pop_i && (fill_q != '0);

  always_comb begin
    cmd_new.kind    = req_i.opcode ? CMD_UNLOCK : CMD_LOCK;
    cmd_new.id      = req_i.requester_id;
    cmd_new.prio    = req_i.requester_priority;
    cmd_new.restore = (req_i.requester_priority != req_i.base_priority);
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(CMD_QDEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(CMD_QDEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push && !pop) begin
      fill_d = fill_q + NW'(1);
    end else if (pop && !push) begin
      fill_d = fill_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_new;
    end
  end

  assign cmd_valid_o = (fill_q != '0);
  assign cmd_o       = slot_q[rd_ptr_q];

endmodule

// File: hdl/rmpi_back.sv
module rmpi_back
  import rmpi_pkg::*;
#(
  parameter int unsigned WAIT_SLOTS = WAIT_SLOTS_DEF,
  parameter int unsigned MAX_NEST   = MAX_NEST_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  output logic res_valid_o,
  output res_t res_o
);

  localparam int unsigned AW = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1;
  localparam int unsigned CW = $clog2(WAIT_SLOTS + 1);
  localparam int unsigned DW = $clog2(MAX_NEST + 1);

  back_state_e       state_q, state_d;
  logic              held_q, held_d;
  logic [ID_W-1:0]   holder_thr_q, holder_thr_d;
  logic [PRIO_W-1:0] holder_lvl_q, holder_lvl_d;
  logic [DW-1:0]     nest_q, nest_d;
  logic [CW-1:0]     count_q, count_d;
  logic              restore_q, restore_d;
  logic [CW-1:0]     iss_q, iss_d;
  logic              pend_q, pend_d;
  logic [AW-1:0]     pend_idx_q, pend_idx_d;
  logic [AW-1:0]     best_idx_q, best_idx_d;
  logic [PRIO_W-1:0] best_lvl_q, best_lvl_d;
  logic [ID_W-1:0]   best_thr_q, best_thr_d;
  logic              res_valid_q, res_valid_d;
  res_t              res_q, res_d;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  entry_t            ram_wdata;
  logic [AW-1:0]     ram_raddr;
  entry_t            ram_rdata;

  rmpi_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (WAIT_SLOTS)
  ) u_wait_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    held_d       = held_q;
    holder_thr_d = holder_thr_q;
    holder_lvl_d = holder_lvl_q;
    nest_d       = nest_q;
    count_d      = count_q;
    restore_d    = restore_q;
    iss_d        = iss_q;
    pend_d       = 1'b0;
    pend_idx_d   = pend_idx_q;
    best_idx_d   = best_idx_q;
    best_lvl_d   = best_lvl_q;
    best_thr_d   = best_thr_q;
    res_valid_d  = 1'b0;
    res_d        = '0;
    res_d.status = ST_NOTHOLDER;
    cmd_pop_o    = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = count_q[AW-1:0];
    ram_wdata    = '0;
    ram_raddr    = iss_q[AW-1:0];

    unique case (state_q)
      B_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o   = 1'b1;
          res_valid_d = 1'b1;
          unique case (cmd_i.kind)
            CMD_LOCK: begin
              if (!held_q) begin
                held_d       = 1'b1;
                holder_thr_d = cmd_i.id;
                holder_lvl_d = cmd_i.prio;
                nest_d       = '0;
                res_d.status = ST_ACQUIRED;
              end else if (holder_thr_q == cmd_i.id) begin
                holder_lvl_d = cmd_i.prio;
                if (nest_q >= DW'(MAX_NEST)) begin
                  res_d.status = ST_DFULL;
                end else begin
                  nest_d       = nest_q + DW'(1);
                  res_d.status = ST_NESTED;
                end
              end else if (count_q >= CW'(WAIT_SLOTS)) begin
                res_d.status = ST_QFULL;
              end else begin
                ram_we           = 1'b1;
                ram_wdata.thread = cmd_i.id;
                ram_wdata.level  = cmd_i.prio;
                count_d          = count_q + CW'(1);
                res_d.status     = ST_BLOCKED;
                if (holder_lvl_q > cmd_i.prio) begin
                  holder_lvl_d         = cmd_i.prio;
                  res_d.boost_valid    = 1'b1;
                  res_d.boost_thread   = holder_thr_q;
                  res_d.boost_priority = cmd_i.prio;
                end
              end
            end
            CMD_UNLOCK: begin
              if (!held_q || holder_thr_q != cmd_i.id) begin
                res_d.status = ST_NOTHOLDER;
              end else if (nest_q != '0) begin
                nest_d       = nest_q - DW'(1);
                res_d.status = ST_UNNEST;
              end else if (count_q == '0) begin
                held_d              = 1'b0;
                res_d.status        = ST_FREED;
                res_d.restore_valid = cmd_i.restore;
              end else begin
                res_valid_d = 1'b0;
                restore_d   = cmd_i.restore;
                iss_d       = '0;
                state_d     = B_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      B_SCAN: begin
        if (iss_q < count_q) begin
          iss_d      = iss_q + CW'(1);
          pend_d     = 1'b1;
          pend_idx_d = iss_q[AW-1:0];
        end
        if (pend_q) begin
          if (pend_idx_q == '0 || ram_rdata.level < best_lvl_q) begin
            best_idx_d = pend_idx_q;
            best_lvl_d = ram_rdata.level;
            best_thr_d = ram_rdata.thread;
          end
        end else if (iss_q == count_q) begin
          iss_d   = CW'(best_idx_q) + CW'(1);
          state_d = B_COMPACT;
        end
      end

      B_COMPACT: begin
        if (iss_q < count_q) begin
          iss_d      = iss_q + CW'(1);
          pend_d     = 1'b1;
          pend_idx_d = AW'(iss_q - CW'(1));
        end
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = pend_idx_q;
          ram_wdata = ram_rdata;
        end else if (iss_q >= count_q) begin
          holder_thr_d        = best_thr_q;
          holder_lvl_d        = best_lvl_q;
          nest_d              = '0;
          count_d             = count_q - CW'(1);
          res_valid_d         = 1'b1;
          res_d.status        = ST_HANDOVER;
          res_d.wake_valid    = 1'b1;
          res_d.wake_thread   = best_thr_q;
          res_d.restore_valid = restore_q;
          state_d             = B_IDLE;
        end
      end

      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= B_IDLE;
      held_q       <= 1'b0;
      holder_thr_q <= '0;
      holder_lvl_q <= '0;
      nest_q       <= '0;
      count_q      <= '0;
      restore_q    <= 1'b0;
      iss_q        <= '0;
      pend_q       <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      held_q       <= held_d;
      holder_thr_q <= holder_thr_d;
      holder_lvl_q <= holder_lvl_d;
      nest_q       <= nest_d;
      count_q      <= count_d;
      restore_q    <= restore_d;
      iss_q        <= iss_d;
      pend_q       <= pend_d;
      res_valid_q  <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    best_idx_q <= best_idx_d;
    best_lvl_q <= best_lvl_d;
    best_thr_q <= best_thr_d;
    res_q      <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(WAIT_SLOTS))
    else $error("wait count beyond table size");

  a_free_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !held_q |-> (count_q == '0 && state_q == B_IDLE))
    else $error("waiters or handover while mutex free");

  a_handover_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.status == ST_HANDOVER) |-> held_q)
    else $error("handover left mutex free");

  a_pend_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == B_SCAN || state_q == B_COMPACT))
    else $error("table read pending outside scan or compact");

  a_handover_shrinks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_COMPACT && state_d == B_IDLE) |=> (count_q == $past(count_q) - CW'(1)))
    else $error("handover did not drop one waiter");
`endif

endmodule

// File: hdl/recursive_mutex_priority_inherit_unit.sv
// Recursive mutex with priority inheritance.
// Request channel: drive req_i and raise start; the beat is taken at a clock
// edge with start high and busy low. busy rises when the two-entry command
// queue between the request front end and the mutex engine is full.
// Result channel: one result per request, on res_o while res_valid_o is high
// for exactly one cycle, in request order. The receiver cannot stall it.
// An accepted request passes the command queue and then the registered result
// stage before its strobe; lock requests, nested unlocks, unlocks by a
// non-holder and unlocks that free the mutex are served from the idle state.
// A handover keeps the engine busy for two passes over the wait-table RAM
// port: one pass finds the most urgent waiter, a second pass shifts later
// entries down one slot, one entry per cycle each.
// Back-to-back requests are queued and served in order behind a handover.
// Reset clears the mutex to free with no waiters and empties the queue;
// wait-table contents are not cleared and are read only below the count.
module recursive_mutex_priority_inherit_unit
  import rmpi_pkg::*;
#(
  parameter int unsigned WAIT_SLOTS = WAIT_SLOTS_DEF,
  parameter int unsigned MAX_NEST   = MAX_NEST_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic res_valid_o,
  output res_t res_o
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  rmpi_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  rmpi_back #(
    .WAIT_SLOTS (WAIT_SLOTS),
    .MAX_NEST   (MAX_NEST)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

// File: test/recursive_mutex_priority_inherit_unit_test.sv
`timescale 1ns / 1ps

module recursive_mutex_priority_inherit_unit_test;
  import rmpi_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1290;
  localparam int unsigned DRAIN_CYCLES = 2 * WAIT_SLOTS_DEF + 32;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic res_valid_o;
  res_t res_o;

  recursive_mutex_priority_inherit_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  logic              mtx_held;
  logic [ID_W-1:0]   mtx_owner;
  logic [PRIO_W-1:0] mtx_level;
  int unsigned       mtx_depth;
  int unsigned       n_waiting;
  logic [ID_W-1:0]   wait_id    [WAIT_SLOTS_DEF];
  logic [PRIO_W-1:0] wait_level [WAIT_SLOTS_DEF];

  res_t        expected_results[$];
  int unsigned beats_sent;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned burst_left;
  int unsigned status_seen[9];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic res_t predict_mutex(input req_t r);
    res_t        o;
    int unsigned best;
    o = '0;
    if (r.opcode == CMD_LOCK) begin
      if (!mtx_held) begin
        mtx_held  = 1'b1;
        mtx_owner = r.requester_id;
        mtx_level = r.requester_priority;
        mtx_depth = 0;
        o.status  = ST_ACQUIRED;
      end else if (mtx_owner == r.requester_id) begin
        mtx_level = r.requester_priority;
        if (mtx_depth >= MAX_NEST_DEF) begin
          o.status = ST_DFULL;
        end else begin
          mtx_depth++;
          o.status = ST_NESTED;
        end
      end else if (n_waiting >= WAIT_SLOTS_DEF) begin
        o.status = ST_QFULL;
      end else begin
        wait_id[n_waiting]    = r.requester_id;
        wait_level[n_waiting] = r.requester_priority;
        n_waiting++;
        o.status = ST_BLOCKED;
        if (mtx_level > r.requester_priority) begin
          mtx_level        = r.requester_priority;
          o.boost_valid    = 1'b1;
          o.boost_thread   = mtx_owner;
          o.boost_priority = r.requester_priority;
        end
      end
    end else begin
      if (!mtx_held || mtx_owner != r.requester_id) begin
        o.status = ST_NOTHOLDER;
      end else if (mtx_depth != 0) begin
        mtx_depth--;
        o.status = ST_UNNEST;
      end else begin
        o.restore_valid = (r.requester_priority != r.base_priority);
        if (n_waiting == 0) begin
          mtx_held = 1'b0;
          o.status = ST_FREED;
        end else begin
          best = 0;
          for (int unsigned i = 1; i < n_waiting; i++) begin
            if (wait_level[i] < wait_level[best]) best = i;
          end
          mtx_owner = wait_id[best];
          mtx_level = wait_level[best];
          mtx_depth = 0;
          for (int unsigned i = best; i + 1 < n_waiting; i++) begin
            wait_id[i]    = wait_id[i+1];
            wait_level[i] = wait_level[i+1];
          end
          n_waiting--;
          o.wake_valid  = 1'b1;
          o.wake_thread = mtx_owner;
          o.status      = ST_HANDOVER;
        end
      end
    end
    return o;
  endfunction

  function automatic req_t mk_req(input cmd_e op, input int unsigned id,
                                  input int unsigned prio, input int unsigned base);
    req_t r;
    r.opcode             = op;
    r.requester_id       = id[ID_W-1:0];
    r.requester_priority = prio[PRIO_W-1:0];
    r.base_priority      = base[PRIO_W-1:0];
    return r;
  endfunction

  function automatic logic [ID_W-1:0] other_thread();
    logic [ID_W-1:0] id;
    id = ID_W'($urandom_range(0, 31));
    if (mtx_held && id == mtx_owner) id = id ^ ID_W'(1);
    return id;
  endfunction

  task automatic send_beat(input req_t r);
    if (burst_left == 0) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat ($urandom_range(0, 7)) @(negedge clk_i);
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    @(negedge clk_i);
    start = 1'b1;
    req_i = r;
    do @(posedge clk_i); while (busy);
    expected_results.push_back(predict_mutex(r));
    beats_sent++;
  endtask

  task automatic test_basic_handover();
    send_beat(mk_req(CMD_LOCK,    0, 255, 255));
    send_beat(mk_req(CMD_LOCK,    0, 200, 255));
    send_beat(mk_req(CMD_UNLOCK, 31, 255, 255));
    send_beat(mk_req(CMD_LOCK,   31,   0, 255));
    send_beat(mk_req(CMD_LOCK,    5,   0,   0));
    send_beat(mk_req(CMD_LOCK,    7, 100, 100));
    send_beat(mk_req(CMD_LOCK,   31,  50,  50));
    send_beat(mk_req(CMD_UNLOCK,  0,   0, 255));
    send_beat(mk_req(CMD_UNLOCK,  0,   0, 255));
    send_beat(mk_req(CMD_UNLOCK, 31,   0,   0));
    send_beat(mk_req(CMD_UNLOCK,  5, 255, 255));
    send_beat(mk_req(CMD_UNLOCK, 31,  50, 170));
    send_beat(mk_req(CMD_UNLOCK,  7,  85, 100));
    send_beat(mk_req(CMD_UNLOCK,  7, 100, 100));
  endtask

  task automatic test_wait_table_full();
    int unsigned p;
    send_beat(mk_req(CMD_LOCK, 3, 128, 128));
    for (int unsigned i = 0; i < WAIT_SLOTS_DEF; i++) begin
      p = $urandom_range(0, 255);
      send_beat(mk_req(CMD_LOCK, other_thread(), p, $urandom_range(0, 255)));
    end
    send_beat(mk_req(CMD_LOCK, other_thread(), 0, 0));
    send_beat(mk_req(CMD_LOCK, 3, 255, 128));
    send_beat(mk_req(CMD_UNLOCK, 3, 255, 128));
    while (mtx_held) begin
      p = $urandom_range(0, 255);
      send_beat(mk_req(CMD_UNLOCK, mtx_owner, p, ($urandom_range(0, 1) != 0) ? p : ~p));
    end
  endtask

  task automatic test_nesting_limit();
    send_beat(mk_req(CMD_LOCK, 9, 60, 60));
    for (int unsigned i = 0; i < MAX_NEST_DEF; i++) begin
      send_beat(mk_req(CMD_LOCK, 9, $urandom_range(0, 255), 60));
    end
    send_beat(mk_req(CMD_LOCK, 9, 40, 60));
    send_beat(mk_req(CMD_LOCK, 22, 10, 10));
    for (int unsigned i = 0; i <= MAX_NEST_DEF; i++) begin
      send_beat(mk_req(CMD_UNLOCK, 9, 10, 60));
    end
    send_beat(mk_req(CMD_UNLOCK, 22, 10, 10));
  endtask

  task automatic test_random_traffic(input int unsigned n);
    int unsigned      roll;
    int unsigned      p;
    int unsigned      b;
    logic [ID_W-1:0]  id;
    cmd_e             op;
    for (int unsigned k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      p    = $urandom_range(0, 255);
      b    = ($urandom_range(0, 1) != 0) ? p : $urandom_range(0, 255);
      if (!mtx_held) begin
        op = (roll < 85) ? CMD_LOCK : CMD_UNLOCK;
        id = ID_W'($urandom_range(0, 31));
      end else if (roll < 38) begin
        op = CMD_LOCK;
        id = other_thread();
      end else if (roll < 52) begin
        op = CMD_LOCK;
        id = mtx_owner;
      end else if (roll < 93) begin
        op = CMD_UNLOCK;
        id = mtx_owner;
      end else begin
        op = CMD_UNLOCK;
        id = ID_W'($urandom_range(0, 31));
      end
      send_beat(mk_req(op, id, p, b));
    end
  endtask

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_valid_o) begin
      results_seen++;
      if (res_o.status <= ST_NOTHOLDER) status_seen[res_o.status]++;
      if (expected_results.size() == 0) begin
        if (mismatches < 10) $display("%0t: result with nothing outstanding: %p", $time, res_o);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (res_o.status !== want.status || res_o.wake_valid !== want.wake_valid ||
            res_o.wake_thread !== want.wake_thread ||
            res_o.boost_valid !== want.boost_valid ||
            res_o.boost_thread !== want.boost_thread ||
            res_o.boost_priority !== want.boost_priority ||
            res_o.restore_valid !== want.restore_valid) begin
          if (mismatches < 10) begin
            $display("%0t: result beat %0d differs", $time, results_seen);
            $display("  expected %p", want);
            $display("  actual   %p", res_o);
          end
          mismatches++;
        end
      end
    end
  end

  initial begin
    start        = 1'b0;
    req_i        = '0;
    rst_ni       = 1'b0;
    mtx_held     = 1'b0;
    mtx_owner    = '0;
    mtx_level    = '0;
    mtx_depth    = 0;
    n_waiting    = 0;
    beats_sent   = 0;
    results_seen = 0;
    mismatches   = 0;
    burst_left   = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_basic_handover();
    test_wait_table_full();
    test_nesting_limit();
    test_random_traffic(RANDOM_ITEMS);

    @(negedge clk_i);
    start = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d request beats, checked %0d results, %0d mismatches.",
             beats_sent, results_seen, mismatches);
    $display("Handovers %0d, freed %0d, blocked %0d, queue full %0d, depth full %0d.",
             status_seen[ST_HANDOVER], status_seen[ST_FREED], status_seen[ST_BLOCKED],
             status_seen[ST_QFULL], status_seen[ST_DFULL]);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/rmpi_pkg.sv
hdl/rmpi_ram.sv
hdl/rmpi_front.sv
hdl/rmpi_back.sv
hdl/recursive_mutex_priority_inherit_unit.sv
test/recursive_mutex_priority_inherit_unit_test.sv
